FILE: hw/rtl/btmx_pkg.sv
// Package for the binary trie maximum-XOR block.
// Holds widths, node store geometry and the sequencer state type.
// No dependencies.
package btmx_pkg;

  // Key width and node store size.
  localparam int unsigned KeyBits   = 32;
  localparam int unsigned NodeCount = 8192;

  // Derived widths: node index, one store entry, node count, bit position.
  localparam int unsigned NodeW = $clog2(NodeCount);
  localparam int unsigned LinkW = 2 * NodeW;
  localparam int unsigned UsedW = $clog2(NodeCount + 1);
  localparam int unsigned PosW  = $clog2(KeyBits);

  // Request codes.
  localparam logic ReqInsert = 1'b0;
  localparam logic ReqQuery  = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StWalk  = 5'b00010,
    StAlloc = 5'b00100,
    StLeaf  = 5'b01000,
    StDone  = 5'b10000
  } state_e;

endpackage

FILE: hw/rtl/btmx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btmx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/binary_trie_max_xor.sv
// Binary trie over 32-bit keys that answers maximum-XOR queries.
// A query reads one node per key bit, then hands off its result; on an empty
// trie it goes straight to the hand-off. An insert that adds nodes walks, writes
// one node per new level and then a leaf; a stored key only walks. One item
// is in work at a time. Reset empties the trie at once: no clearing pass.
// Depends on btmx_pkg and btmx_ram.
module binary_trie_max_xor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [btmx_pkg::KeyBits-1:0]  key_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [btmx_pkg::KeyBits-1:0]  best_xor_o,
  output logic                          found_o,
  output logic                          store_full_o
);

  localparam int unsigned NodeW = btmx_pkg::NodeW;
  localparam int unsigned LinkW = btmx_pkg::LinkW;
  localparam int unsigned UsedW = btmx_pkg::UsedW;
  localparam int unsigned PosW  = btmx_pkg::PosW;
  localparam int unsigned KeyW  = btmx_pkg::KeyBits;

  btmx_pkg::state_e state_q, state_d;

  logic                 req_q, req_d;
  logic [KeyW-1:0]      key_q, key_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [NodeW-1:0]     node_q, node_d;
  logic [LinkW-1:0]     cur_links_q, cur_links_d;
  logic [KeyW-1:0]      best_q, best_d;
  logic                 found_q, found_d;
  logic                 full_q, full_d;
  logic [UsedW-1:0]     nodes_used_q, nodes_used_d;
  logic                 trie_empty_q, trie_empty_d;

  logic                 out_valid_q, out_valid_d;
  logic [KeyW-1:0]      out_best_q, out_best_d;
  logic                 out_found_q, out_found_d;
  logic                 out_full_q, out_full_d;

  logic                 ram_we;
  logic [NodeW-1:0]     ram_waddr;
  logic [LinkW-1:0]     ram_wdata;
  logic [NodeW-1:0]     ram_raddr;
  logic [LinkW-1:0]     ram_rdata;

  logic [LinkW-1:0]     links;
  logic                 cur_bit;
  logic [NodeW-1:0]     link_same;
  logic [NodeW-1:0]     link_other;
  logic [UsedW:0]       need_total;
  logic                 in_fire;

  // Node store: two child links per entry, link 0 in the low half.
  btmx_ram #(
    .Width(LinkW),
    .Depth(btmx_pkg::NodeCount)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o = (state_q == btmx_pkg::StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  // The root is never written before the first insert; an empty trie reads null links.
  assign links      = trie_empty_q ? '0 : ram_rdata;
  assign cur_bit    = key_q[pos_q];
  assign link_same  = cur_bit ? links[LinkW-1:NodeW] : links[NodeW-1:0];
  assign link_other = cur_bit ? links[NodeW-1:0] : links[LinkW-1:NodeW];

  // Total node count if the missing levels below this one were allocated.
  assign need_total = {1'b0, nodes_used_q} + (UsedW + 1)'(pos_q) + (UsedW + 1)'(1);

  // Sequencer: walk the trie one level per cycle; an insert then allocates any missing levels.
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    key_d        = key_q;
    pos_d        = pos_q;
    node_d       = node_q;
    cur_links_d  = cur_links_q;
    best_d       = best_q;
    found_d      = found_q;
    full_d       = full_q;
    nodes_used_d = nodes_used_q;
    trie_empty_d = trie_empty_q;
    out_valid_d  = out_valid_q;
    out_best_d   = out_best_q;
    out_found_d  = out_found_q;
    out_full_d   = out_full_q;
    ram_we       = 1'b0;
    ram_waddr    = node_q;
    ram_wdata    = '0;
    ram_raddr    = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      btmx_pkg::StIdle: begin
        if (in_fire) begin
          req_d   = req_type_i;
          key_d   = key_i;
          pos_d   = PosW'(KeyW - 1);
          node_d  = '0;
          best_d  = '0;
          found_d = 1'b0;
          full_d  = 1'b0;
          if (req_type_i == btmx_pkg::ReqQuery && trie_empty_q) begin
            state_d = btmx_pkg::StDone;
          end else begin
            found_d = (req_type_i == btmx_pkg::ReqQuery);
            state_d = btmx_pkg::StWalk;
          end
        end
      end

      btmx_pkg::StWalk: begin
        if (req_q == btmx_pkg::ReqQuery) begin
          // Prefer the opposite bit; fall back to the same bit.
          if (link_other != '0) begin
            best_d[pos_q] = 1'b1;
            node_d        = link_other;
          end else begin
            node_d = link_same;
          end
          ram_raddr = node_d;
          if (pos_q == '0 || node_d == '0) begin
            state_d = btmx_pkg::StDone;
          end else begin
            pos_d = pos_q - PosW'(1);
          end
        end else begin
          if (link_same != '0) begin
            node_d    = link_same;
            ram_raddr = link_same;
            if (pos_q == '0) begin
              state_d = btmx_pkg::StDone;
            end else begin
              pos_d = pos_q - PosW'(1);
            end
          end else if (need_total > (UsedW + 1)'(btmx_pkg::NodeCount)) begin
            full_d  = 1'b1;
            state_d = btmx_pkg::StDone;
          end else begin
            cur_links_d = links;
            state_d     = btmx_pkg::StAlloc;
          end
        end
      end

      btmx_pkg::StAlloc: begin
        // Link the parent to a fresh node; the fresh node starts with null links.
        ram_we    = 1'b1;
        ram_waddr = node_q;
        ram_wdata = cur_links_q;
        if (cur_bit) begin
          ram_wdata[LinkW-1:NodeW] = nodes_used_q[NodeW-1:0];
        end else begin
          ram_wdata[NodeW-1:0] = nodes_used_q[NodeW-1:0];
        end
        node_d       = nodes_used_q[NodeW-1:0];
        nodes_used_d = nodes_used_q + UsedW'(1);
        cur_links_d  = '0;
        if (pos_q == '0) begin
          state_d = btmx_pkg::StLeaf;
        end else begin
          pos_d = pos_q - PosW'(1);
        end
      end

      btmx_pkg::StLeaf: begin
        // The leaf node gets its null links written.
        ram_we       = 1'b1;
        ram_waddr    = node_q;
        ram_wdata    = '0;
        trie_empty_d = 1'b0;
        state_d      = btmx_pkg::StDone;
      end

      btmx_pkg::StDone: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_best_d  = best_q;
          out_found_d = found_q;
          out_full_d  = full_q;
          state_d     = btmx_pkg::StIdle;
        end
      end

      default: begin
        state_d = btmx_pkg::StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= btmx_pkg::StIdle;
      nodes_used_q <= UsedW'(1);
      trie_empty_q <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      nodes_used_q <= nodes_used_d;
      trie_empty_q <= trie_empty_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    key_q       <= key_d;
    pos_q       <= pos_d;
    node_q      <= node_d;
    cur_links_q <= cur_links_d;
    best_q      <= best_d;
    found_q     <= found_d;
    full_q      <= full_d;
    out_best_q  <= out_best_d;
    out_found_q <= out_found_d;
    out_full_q  <= out_full_d;
  end

  assign out_valid_o  = out_valid_q;
  assign best_xor_o   = out_best_q;
  assign found_o      = out_found_q;
  assign store_full_o = out_full_q;

endmodule

FILE: tb/binary_trie_max_xor_tb.sv
// Self-checking testbench for binary_trie_max_xor: inserts and max-XOR queries are
// checked against an in-bench trie model, with random sender gaps and receiver stalls.
// Depends on btmx_pkg and the binary_trie_max_xor RTL.
module binary_trie_max_xor_tb;

  localparam int unsigned KeyBits   = btmx_pkg::KeyBits;
  localparam int unsigned NodeW     = btmx_pkg::NodeW;
  localparam int unsigned NodeCount = btmx_pkg::NodeCount;
  localparam logic        ReqInsert = btmx_pkg::ReqInsert;
  localparam logic        ReqQuery  = btmx_pkg::ReqQuery;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 80;
  localparam int RandomItems   = 1450;

  typedef struct packed {
    logic                req;
    logic [KeyBits-1:0]  key;
  } trie_req_t;

  typedef struct packed {
    logic [KeyBits-1:0]  best_xor;
    logic                found;
    logic                store_full;
  } trie_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               req_type_i  = 1'b0;
  logic [KeyBits-1:0] key_i       = '0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [KeyBits-1:0] best_xor_o;
  logic               found_o;
  logic               store_full_o;

  binary_trie_max_xor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .best_xor_o  (best_xor_o),
    .found_o     (found_o),
    .store_full_o(store_full_o)
  );

  // Clock: period of 20 time units.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow trie: two child links per node, node 0 is the root.
  logic [NodeW-1:0] link_zero [NodeCount];
  logic [NodeW-1:0] link_one  [NodeCount];
  int unsigned      nodes_used = 1;
  bit               trie_empty = 1'b1;

  trie_req_t          pending_items [$];
  trie_result_t       expected_results [$];
  logic [KeyBits-1:0] stored_keys [$];

  int  items_pushed   = 0;
  int  items_accepted = 0;
  int  mismatches     = 0;
  int  insert_count   = 0;
  int  refused_count  = 0;
  int  query_count    = 0;
  int  empty_queries  = 0;
  int  idle_cycles    = 0;
  int  random_sent    = 0;
  bit  in_taken       = 1'b0;
  int  send_burst     = 4;
  int  send_gap       = 0;
  int  run_left       = 0;
  int  hold_left      = 0;
  trie_req_t drive_item;

  initial begin
    for (int i = 0; i < NodeCount; i++) begin
      link_zero[i] = '0;
      link_one[i]  = '0;
    end
  end

  function automatic logic [NodeW-1:0] child_of(int unsigned node, logic bit_val);
    return bit_val ? link_one[node] : link_zero[node];
  endfunction

  // Insert a key into the shadow trie. Returns 1 when the node store cannot take it.
  function automatic logic trie_insert(logic [KeyBits-1:0] k);
    int          pos;
    int unsigned node;
    int unsigned needed;
    node = 0;
    pos  = KeyBits - 1;
    while (pos >= 0 && child_of(node, k[pos]) != 0) begin
      node = 32'(child_of(node, k[pos]));
      pos--;
    end
    needed = pos + 1;
    if (needed > NodeCount - nodes_used) return 1'b1;
    // Allocate the missing levels, each new node with null links.
    while (pos >= 0) begin
      link_zero[nodes_used] = '0;
      link_one[nodes_used]  = '0;
      if (k[pos]) link_one[node] = NodeW'(nodes_used);
      else link_zero[node] = NodeW'(nodes_used);
      node = nodes_used;
      nodes_used++;
      pos--;
    end
    trie_empty = 1'b0;
    return 1'b0;
  endfunction

  // Greedy walk that takes the opposite bit whenever that child exists.
  function automatic logic [KeyBits-1:0] trie_best_xor(logic [KeyBits-1:0] k);
    int                 pos;
    int unsigned        node;
    int unsigned        other;
    logic [KeyBits-1:0] best;
    bit                 stop;
    node = 0;
    best = '0;
    stop = 1'b0;
    for (pos = KeyBits - 1; pos >= 0 && !stop; pos--) begin
      other = 32'(child_of(node, ~k[pos]));
      if (other != 0) begin
        best[pos] = 1'b1;
        node = other;
      end else begin
        node = 32'(child_of(node, k[pos]));
        stop = (node == 0);
      end
    end
    return best;
  endfunction

  // Expected result of one accepted item; also keeps the run statistics.
  function automatic trie_result_t trie_expect(trie_req_t item);
    trie_result_t res;
    res = '0;
    if (item.req == ReqInsert) begin
      insert_count++;
      res.store_full = trie_insert(item.key);
      if (res.store_full) refused_count++;
    end else begin
      query_count++;
      if (trie_empty) begin
        empty_queries++;
      end else begin
        res.best_xor = trie_best_xor(item.key);
        res.found    = 1'b1;
      end
    end
    return res;
  endfunction

  // Input acceptance and result checking, both at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(trie_expect('{req_type_i, key_i}));
        items_accepted++;
        in_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: best_xor %h found %b store_full %b",
                 best_xor_o, found_o, store_full_o);
          mismatches++;
        end else begin
          trie_result_t exp_res;
          exp_res = expected_results.pop_front();
          if (best_xor_o !== exp_res.best_xor) begin
            $error("best_xor: expected %h, got %h", exp_res.best_xor, best_xor_o);
            mismatches++;
          end
          if (found_o !== exp_res.found) begin
            $error("found: expected %b, got %b", exp_res.found, found_o);
            mismatches++;
          end
          if (store_full_o !== exp_res.store_full) begin
            $error("store_full: expected %b, got %b", exp_res.store_full, store_full_o);
            mismatches++;
          end
        end
      end
    end
  end

  // Sender: bursts of items separated by random gaps; the payload is noise during gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
        req_type_i <= 1'($urandom);
        key_i      <= $urandom;
      end else if (pending_items.size() != 0) begin
        drive_item = pending_items.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= drive_item.req;
        key_i      <= drive_item.key;
        if (send_burst > 0) send_burst--;
        if (send_burst == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            send_burst = 100;
            send_gap   = 0;
          end else begin
            send_burst = $urandom_range(1, 8);
            send_gap   = $urandom_range(1, 12);
          end
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: runs of ready broken by stalls, with an occasional long stall-free run.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (run_left > 0) begin
        run_left--;
      end else begin
        run_left  = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 10);
        hold_left = $urandom_range(1, 16);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic queue_item(logic req, logic [KeyBits-1:0] k);
    pending_items.push_back('{req, k});
    items_pushed++;
    if (req == ReqInsert) stored_keys.push_back(k);
  endtask

  function automatic logic [KeyBits-1:0] pick_stored();
    if (stored_keys.size() == 0) return $urandom;
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  // Mostly keys related to stored ones, so queries exercise deep matching paths.
  task automatic queue_mixed_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) queue_item(ReqInsert, $urandom);
    else if (pick < 30) queue_item(ReqInsert, pick_stored() ^ $urandom_range(1, 255));
    else if (pick < 38) queue_item(ReqInsert, pick_stored());
    else if (pick < 60) queue_item(ReqQuery, $urandom);
    else if (pick < 75) queue_item(ReqQuery, pick_stored());
    else if (pick < 90) queue_item(ReqQuery, ~pick_stored());
    else queue_item(ReqQuery, pick_stored() ^ $urandom_range(1, 255));
    random_sent++;
  endtask

  task automatic wait_drained();
    while (items_accepted != items_pushed || expected_results.size() != 0) @(negedge clk_i);
  endtask

  // Stimulus and end of run.
  initial begin
    int guard;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty trie, extreme keys, duplicates and alternating patterns.
    queue_item(ReqQuery,  32'h0000_0000);
    queue_item(ReqQuery,  32'hFFFF_FFFF);
    queue_item(ReqInsert, 32'h0000_0000);
    queue_item(ReqQuery,  32'h0000_0000);
    queue_item(ReqQuery,  32'hFFFF_FFFF);
    queue_item(ReqInsert, 32'h0000_0000);
    queue_item(ReqInsert, 32'hFFFF_FFFF);
    queue_item(ReqQuery,  32'h0000_0000);
    queue_item(ReqQuery,  32'hFFFF_FFFF);
    queue_item(ReqInsert, 32'h8000_0000);
    queue_item(ReqInsert, 32'h7FFF_FFFF);
    queue_item(ReqQuery,  32'h8000_0000);
    queue_item(ReqQuery,  32'hAAAA_AAAA);
    queue_item(ReqInsert, 32'h5555_5555);
    queue_item(ReqQuery,  32'hAAAA_AAAA);
    queue_item(ReqInsert, 32'h0000_0001);
    queue_item(ReqQuery,  32'h0000_0001);
    queue_item(ReqInsert, 32'h1234_5678);
    queue_item(ReqQuery,  32'hEDCB_A987);
    queue_item(ReqQuery,  32'h0001_0000);
    queue_item(ReqInsert, 32'hFFFF_FFFF);

    // Mixed traffic on a partly filled trie.
    for (int i = 0; i < 650; i++) queue_mixed_item();

    // Hold the sender until every outstanding result is back.
    wait_drained();

    // Fill the node store with fresh keys until inserts start to be refused.
    guard = 0;
    while (refused_count < 12 && guard < 900) begin
      @(negedge clk_i);
      if (pending_items.size() < 2) begin
        if (guard % 4 == 3) queue_item(ReqQuery, $urandom);
        else queue_item(ReqInsert, $urandom);
        guard++;
        random_sent++;
      end
    end

    // Traffic on the full store: duplicates still succeed, new paths are refused.
    while (random_sent < RandomItems) queue_mixed_item();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d inserts (%0d refused on a full node store) and %0d queries",
             insert_count, refused_count, query_count);
    $display("(%0d on an empty trie); %0d of %0d trie nodes were in use at the end.",
             empty_queries, nodes_used, NodeCount);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
